>>> hdl/u8d2i_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package u8d2i_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       is_last;
  } u8d2i_in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] parsed_value;
  } u8d2i_out_t;

  typedef struct packed {
    logic [1:0]  pending;
    logic [1:0]  seq_len;
    logic [20:0] partial;
  } u8d2i_dec_st_t;

  typedef struct packed {
    logic          sign_seen;
    logic          sign_neg;
    u8d2i_dec_st_t dec;
    logic          cp_valid;
    logic [15:0]   cp;
    logic          err;
  } u8d2i_dec_res_t;

  typedef struct packed {
    logic        digit_ok;
    logic        ovf;
    logic [31:0] mag;
  } u8d2i_acc_res_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [1:0] SEQ_LEN2 = 2'd2;
  localparam logic [1:0] SEQ_LEN3 = 2'd3;

  localparam logic [20:0] MAX_CP  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;

  localparam int NUM_ZERO_PTS = 37;

  localparam logic [15:0] ZERO_PTS [NUM_ZERO_PTS] = '{
    16'h0030, 16'h0660, 16'h06F0, 16'h07C0, 16'h0966, 16'h09E6, 16'h0A66, 16'h0AE6,
    16'h0B66, 16'h0BE6, 16'h0C66, 16'h0CE6, 16'h0D66, 16'h0DE6, 16'h0E50, 16'h0ED0,
    16'h0F20, 16'h1040, 16'h1090, 16'h17E0, 16'h1810, 16'h1946, 16'h19D0, 16'h1A80,
    16'h1A90, 16'h1B50, 16'h1BB0, 16'h1C40, 16'h1C50, 16'hA620, 16'hA8D0, 16'hA900,
    16'hA9D0, 16'hA9F0, 16'hAA50, 16'hABF0, 16'hFF10
  };

endpackage
`default_nettype wire

>>> hdl/u8d2i_utf8_dec.sv
`timescale 1ns / 1ps
`default_nettype none
module u8d2i_utf8_dec (
  input  wire logic [7:0]             byte_i,
  input  wire logic                   at_start_i,
  input  wire logic                   failed_i,
  input  wire u8d2i_pkg::u8d2i_dec_st_t dec_i,
  output u8d2i_pkg::u8d2i_dec_res_t   res_o
);
  import u8d2i_pkg::*;

  logic [20:0] cont;
  logic [1:0]  pend_dec;
  logic [20:0] min_cp;

  assign cont     = {dec_i.partial[14:0], byte_i[5:0]};
  assign pend_dec = dec_i.pending - 2'd1;

  always_comb begin
    case (dec_i.seq_len)
      SEQ_LEN2: min_cp = 21'h000080;
      SEQ_LEN3: min_cp = 21'h000800;
      default:  min_cp = 21'h010000;
    endcase
  end

  always_comb begin
    res_o           = '0;
    res_o.dec       = dec_i;
    if (at_start_i && (byte_i == CH_PLUS || byte_i == CH_MINUS)) begin
      res_o.sign_seen = 1'b1;
      res_o.sign_neg  = (byte_i == CH_MINUS);
    end else if (!failed_i) begin
      if (dec_i.pending == 2'd0) begin
        if (byte_i[7] == 1'b0) begin
          res_o.cp_valid = 1'b1;
          res_o.cp       = {8'd0, byte_i};
        end else if (byte_i inside {[8'hC2:8'hDF]}) begin
          res_o.dec.partial = {16'd0, byte_i[4:0]};
          res_o.dec.pending = 2'd1;
          res_o.dec.seq_len = 2'd2;
        end else if (byte_i inside {[8'hE0:8'hEF]}) begin
          res_o.dec.partial = {17'd0, byte_i[3:0]};
          res_o.dec.pending = 2'd2;
          res_o.dec.seq_len = 2'd3;
        end else if (byte_i inside {[8'hF0:8'hF4]}) begin
          res_o.dec.partial = {18'd0, byte_i[2:0]};
          res_o.dec.pending = 2'd3;
          res_o.dec.seq_len = 2'd0;
        end else begin
          res_o.err = 1'b1;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        res_o.err = 1'b1;
      end else begin
        res_o.dec.partial = cont;
        res_o.dec.pending = pend_dec;
        if (pend_dec == 2'd0) begin
          res_o.dec.partial = '0;
          res_o.dec.seq_len = 2'd0;
          if (cont < min_cp || cont > MAX_CP || (cont >= SURR_LO && cont <= SURR_HI)) begin
            res_o.err = 1'b1;
          end else if (cont[20:16] != 5'd0) begin
            res_o.err = 1'b1;
          end else begin
            res_o.cp_valid = 1'b1;
            res_o.cp       = cont[15:0];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/u8d2i_accum.sv
`timescale 1ns / 1ps
`default_nettype none
module u8d2i_accum (
  input  wire logic [15:0]             cp_i,
  input  wire logic                    neg_i,
  input  wire logic [31:0]             mag_i,
  output u8d2i_pkg::u8d2i_acc_res_t    res_o
);
  import u8d2i_pkg::*;

  logic        found;
  logic [3:0]  digit;
  logic [35:0] sum;
  logic [35:0] limit;

  always_comb begin
    found = 1'b0;
    digit = 4'd0;
    for (int i = 0; i < NUM_ZERO_PTS; i++) begin
      if (cp_i >= ZERO_PTS[i] && cp_i <= ZERO_PTS[i] + 16'd9) begin
        found = 1'b1;
        digit = 4'(cp_i - ZERO_PTS[i]);
      end
    end
  end

  assign sum   = {1'b0, mag_i, 3'b000} + {3'b000, mag_i, 1'b0} + {32'd0, digit};
  assign limit = neg_i ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;

  assign res_o.digit_ok = found;
  assign res_o.ovf      = (sum > limit);
  assign res_o.mag      = sum[31:0];

endmodule
`default_nettype wire

>>> hdl/utf8_decimal_to_int32_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Port group  Handshake              Payload
// in_         in_valid / in_ready    in_data  (byte_value, has_byte, is_last)
// out_        out_valid / out_ready  out_data (ok, parsed_value)
//
// One item per cycle but for the stall below: an item is held in the input
// register, then the UTF-8 decode, digit lookup and multiply-by-ten accumulate
// update the string state. An item with is_last loads the result register.
// Reset (synchronous, rst_n low) empties both registers and starts a new string.
// A stalled result holds the last item in the input register; other items flow.
module utf8_decimal_to_int32_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire u8d2i_pkg::u8d2i_in_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output u8d2i_pkg::u8d2i_out_t      out_data
);
  import u8d2i_pkg::*;

  u8d2i_in_t      in_r;
  logic           in_v_r;
  logic           at_start_r, at_start_nxt;
  logic           neg_r, neg_nxt;
  logic           seen_r, seen_nxt;
  logic           failed_r, failed_nxt;
  logic [31:0]    mag_r, mag_nxt;
  u8d2i_dec_st_t  dec_r, dec_nxt;
  u8d2i_out_t     out_r, out_nxt;
  logic           out_v_r, out_v_nxt;

  u8d2i_dec_res_t dec_res;
  u8d2i_acc_res_t acc_res;
  logic           out_free;
  logic           step_fire;
  logic           good;
  logic           digit_take;

  assign out_free  = !out_v_r || out_ready;
  assign step_fire = in_v_r && (!in_r.is_last || out_free);
  assign in_ready  = !in_v_r || step_fire;

  u8d2i_utf8_dec u_dec (
    .byte_i     (in_r.byte_value),
    .at_start_i (at_start_r),
    .failed_i   (failed_r),
    .dec_i      (dec_r),
    .res_o      (dec_res)
  );

  u8d2i_accum u_acc (
    .cp_i  (dec_res.cp),
    .neg_i (neg_r),
    .mag_i (mag_r),
    .res_o (acc_res)
  );

  assign digit_take = dec_res.cp_valid && acc_res.digit_ok && !acc_res.ovf;

  always_comb begin
    at_start_nxt = at_start_r;
    neg_nxt      = neg_r;
    seen_nxt     = seen_r;
    failed_nxt   = failed_r;
    mag_nxt      = mag_r;
    dec_nxt      = dec_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_nxt      = out_r;
    good         = 1'b0;
    if (step_fire) begin
      if (in_r.has_byte) begin
        at_start_nxt = 1'b0;
        if (dec_res.sign_seen) begin
          neg_nxt = dec_res.sign_neg;
        end
        dec_nxt    = dec_res.dec;
        failed_nxt = failed_r || dec_res.err || (dec_res.cp_valid && !digit_take);
        if (digit_take) begin
          mag_nxt  = acc_res.mag;
          seen_nxt = 1'b1;
        end
      end
      if (in_r.is_last) begin
        good                 = !failed_nxt && seen_nxt && (dec_nxt.pending == 2'd0);
        out_v_nxt            = 1'b1;
        out_nxt.ok           = good;
        out_nxt.parsed_value = !good ? 32'sd0 :
                               neg_nxt ? $signed(32'd0 - mag_nxt) : $signed(mag_nxt);
        at_start_nxt         = 1'b1;
        neg_nxt              = 1'b0;
        seen_nxt             = 1'b0;
        failed_nxt           = 1'b0;
        mag_nxt              = '0;
        dec_nxt              = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      at_start_r <= 1'b1;
      neg_r      <= 1'b0;
      seen_r     <= 1'b0;
      failed_r   <= 1'b0;
      mag_r      <= '0;
      dec_r      <= '0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      out_v_r    <= out_v_nxt;
      at_start_r <= at_start_nxt;
      neg_r      <= neg_nxt;
      seen_r     <= seen_nxt;
      failed_r   <= failed_nxt;
      mag_r      <= mag_nxt;
      dec_r      <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
